FILE: rtl/core/mfrag_pkg.sv
package mfrag_pkg;

   // widths of the payload fields
   localparam int LENGTH_BITS = 24;
   localparam int MSG_LEN_W   = 24;
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;

   // stream data widths, packed from the lowest bit up and padded to whole bytes
   localparam int REQ_DATA_W = ((BYTE_W + MSG_LEN_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((BYTE_W + WORD_W + 7) / 8) * 8;

   // datagram header
   localparam int                HDR_BYTES  = 8;
   localparam int                HDR_IDX_W  = $clog2(HDR_BYTES);
   localparam logic [WORD_W-1:0] MAGIC_WORD = 16'h0008;

   // header byte positions
   localparam logic [HDR_IDX_W-1:0] HDR_MAGIC_HI = 3'd0;
   localparam logic [HDR_IDX_W-1:0] HDR_MAGIC_LO = 3'd1;
   localparam logic [HDR_IDX_W-1:0] HDR_ID_HI    = 3'd2;
   localparam logic [HDR_IDX_W-1:0] HDR_ID_LO    = 3'd3;
   localparam logic [HDR_IDX_W-1:0] HDR_SEQ_HI   = 3'd4;
   localparam logic [HDR_IDX_W-1:0] HDR_SEQ_LO   = 3'd5;
   localparam logic [HDR_IDX_W-1:0] HDR_TOTAL_HI = 3'd6;
   localparam logic [HDR_IDX_W-1:0] HDR_TOTAL_LO = 3'd7;

   // packet size register
   localparam logic [WORD_W-1:0] PKT_SIZE_RESET = 16'd1472;
   localparam logic [WORD_W-1:0] PKT_SIZE_MIN   = 16'd9;

   // divider step counter
   localparam int DIV_CNT_W = $clog2(LENGTH_BITS + 1);

   // one queued job from front to back
   typedef struct packed {
      logic [BYTE_W-1:0]      data_byte;
      logic                   first;
      logic [WORD_W-1:0]      msg_id;
      logic [WORD_W-1:0]      payload;
      logic [WORD_W-1:0]      frag_total;
      logic [LENGTH_BITS-1:0] length;
   } entry_type;

   // divider status towards the front
   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic [LENGTH_BITS-1:0] quotient;
      logic                   rem_nonzero;
   } div_result_type;

endpackage

FILE: rtl/core/mfrag_divider.sv
module mfrag_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [mfrag_pkg::LENGTH_BITS-1:0]   dividend,
   input  logic [mfrag_pkg::WORD_W-1:0]        divisor,
   output mfrag_pkg::div_result_type           result
);

   logic                                busy_ff;
   logic                                done_ff;
   logic [mfrag_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic [mfrag_pkg::LENGTH_BITS-1:0]   num_ff;
   logic [mfrag_pkg::WORD_W-1:0]        rem_ff;
   logic [mfrag_pkg::WORD_W-1:0]        div_ff;

   logic [mfrag_pkg::WORD_W:0]          shifted;
   logic [mfrag_pkg::WORD_W:0]          diff;
   logic                                ge;
   logic [mfrag_pkg::WORD_W-1:0]        rem_step;

   // one restoring step: bring down the next dividend bit
   always_comb begin
      shifted  = {rem_ff, num_ff[mfrag_pkg::LENGTH_BITS-1]};
      diff     = shifted - {1'b0, div_ff};
      ge       = (shifted >= {1'b0, div_ff});
      rem_step = ge ? diff[mfrag_pkg::WORD_W-1:0] : shifted[mfrag_pkg::WORD_W-1:0];
   end

   // step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == mfrag_pkg::DIV_CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= mfrag_pkg::DIV_CNT_W'(mfrag_pkg::LENGTH_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - mfrag_pkg::DIV_CNT_W'(1);
            if (cnt_ff == mfrag_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // operand and partial result registers, quotient bits shift in from the right
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         num_ff <= {num_ff[mfrag_pkg::LENGTH_BITS-2:0], ge};
         rem_ff <= rem_step;
      end
   end

   assign result.busy        = busy_ff;
   assign result.done        = done_ff;
   assign result.quotient    = num_ff;
   assign result.rem_nonzero = (rem_ff != '0);

endmodule

FILE: rtl/core/mfrag_queue.sv
module mfrag_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mfrag_pkg::entry_type  push_entry,
   input  logic                  pop,
   output logic                  full,
   output logic                  valid,
   output mfrag_pkg::entry_type  head
);

   mfrag_pkg::entry_type mem_ff [2];
   logic                 wr_ptr_ff;
   logic                 rd_ptr_ff;
   logic [1:0]           count_ff;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

endmodule

FILE: rtl/core/mfrag_front.sv
module mfrag_front (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mfrag_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [0:0]                           req_tuser,
   // packet size write
   input  logic                                 csr_valid,
   input  logic [mfrag_pkg::WORD_W-1:0]         csr_data,
   // queue side
   input  logic                                 q_full,
   output logic                                 q_push,
   output mfrag_pkg::entry_type                 q_entry,
   // divider
   output logic                                 div_start,
   output logic [mfrag_pkg::LENGTH_BITS-1:0]    div_dividend,
   output logic [mfrag_pkg::WORD_W-1:0]         div_divisor,
   input  mfrag_pkg::div_result_type            div_result
);

   typedef enum logic [1:0] {
      FE_IDLE = 2'b01,
      FE_DIV  = 2'b10
   } front_state_type;

   front_state_type                    state_ff, state_in;
   logic [mfrag_pkg::WORD_W-1:0]       pkt_size_ff;
   logic [mfrag_pkg::WORD_W-1:0]       msg_id_ff, msg_id_in;
   logic [mfrag_pkg::LENGTH_BITS-1:0]  rem_ff, rem_in;
   mfrag_pkg::entry_type               hold_ff;

   logic                               accept;
   logic                               first;
   logic [mfrag_pkg::BYTE_W-1:0]       data_byte;
   logic [mfrag_pkg::LENGTH_BITS-1:0]  length;
   logic [mfrag_pkg::WORD_W-1:0]       payload;
   logic                               push_byte;
   logic [mfrag_pkg::WORD_W-1:0]       frag_total;

   // field unpacking
   assign data_byte = req_tdata[mfrag_pkg::BYTE_W-1:0];
   assign length    = mfrag_pkg::LENGTH_BITS'(
                         req_tdata[mfrag_pkg::BYTE_W +: mfrag_pkg::MSG_LEN_W]);
   assign first     = req_tuser[0];

   assign req_tready = (state_ff == FE_IDLE) && !q_full;
   assign accept     = req_tvalid && req_tready;

   // payload bytes per datagram, packet size clamped to one payload byte
   assign payload = ((pkt_size_ff < mfrag_pkg::PKT_SIZE_MIN) ? mfrag_pkg::PKT_SIZE_MIN
                                                             : pkt_size_ff)
                    - mfrag_pkg::WORD_W'(mfrag_pkg::HDR_BYTES);

   // classification of the accepted transaction
   assign push_byte    = accept && !first && (rem_ff != '0);
   assign div_start    = accept && first && (length != '0);
   assign div_dividend = length;
   assign div_divisor  = payload;
   assign frag_total   = div_result.quotient[mfrag_pkg::WORD_W-1:0]
                         + mfrag_pkg::WORD_W'(div_result.rem_nonzero);

   // entry towards the back
   always_comb begin
      q_push  = 1'b0;
      q_entry = '0;
      if ((state_ff == FE_DIV) && div_result.done) begin
         q_push             = 1'b1;
         q_entry            = hold_ff;
         q_entry.frag_total = frag_total;
      end else if (push_byte) begin
         q_push            = 1'b1;
         q_entry.data_byte = data_byte;
      end
   end

   // message bookkeeping
   always_comb begin
      state_in  = state_ff;
      msg_id_in = msg_id_ff;
      rem_in    = rem_ff;
      case (state_ff)
         FE_IDLE: begin
            if (accept && first) begin
               msg_id_in = msg_id_ff + mfrag_pkg::WORD_W'(1);
               if (length != '0) begin
                  rem_in   = length - mfrag_pkg::LENGTH_BITS'(1);
                  state_in = FE_DIV;
               end else begin
                  rem_in = '0;
               end
            end else if (push_byte) begin
               rem_in = rem_ff - mfrag_pkg::LENGTH_BITS'(1);
            end
         end
         FE_DIV: begin
            if (div_result.done) begin
               state_in = FE_IDLE;
            end
         end
         default: begin
            state_in = FE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FE_IDLE;
         pkt_size_ff <= mfrag_pkg::PKT_SIZE_RESET;
         msg_id_ff   <= '0;
         rem_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         msg_id_ff <= msg_id_in;
         rem_ff    <= rem_in;
         if (csr_valid) begin
            pkt_size_ff <= csr_data;
         end
      end
   end

   // opening item held while the fragment total is worked out
   always_ff @(posedge clock) begin
      if (div_start) begin
         hold_ff.data_byte  <= data_byte;
         hold_ff.first      <= 1'b1;
         hold_ff.msg_id     <= msg_id_ff;
         hold_ff.payload    <= payload;
         hold_ff.frag_total <= '0;
         hold_ff.length     <= length;
      end
   end

endmodule

FILE: rtl/core/mfrag_back.sv
module mfrag_back (
   input  logic                                 clock,
   input  logic                                 reset,
   // queue side
   input  logic                                 q_valid,
   input  mfrag_pkg::entry_type                 q_head,
   output logic                                 q_pop,
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mfrag_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   output logic [0:0]                           rsp_tuser
);

   typedef enum logic [2:0] {
      BE_IDLE    = 3'b001,
      BE_HEADER  = 3'b010,
      BE_PAYLOAD = 3'b100
   } back_state_type;

   back_state_type                       state_ff, state_in;
   logic [mfrag_pkg::LENGTH_BITS-1:0]    brem_ff, brem_in;
   logic [mfrag_pkg::WORD_W-1:0]         seq_ff, seq_in;
   logic [mfrag_pkg::WORD_W-1:0]         total_ff, total_in;
   logic [mfrag_pkg::WORD_W-1:0]         cid_ff, cid_in;
   logic [mfrag_pkg::WORD_W-1:0]         pay_ff, pay_in;
   logic [mfrag_pkg::WORD_W-1:0]         pleft_ff, pleft_in;
   logic [mfrag_pkg::WORD_W-1:0]         dlen_ff, dlen_in;
   logic [mfrag_pkg::BYTE_W-1:0]         byte_ff, byte_in;
   logic [mfrag_pkg::HDR_IDX_W-1:0]      hidx_ff, hidx_in;

   // output register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [mfrag_pkg::BYTE_W-1:0]         rsp_byte_ff, rsp_byte_in;
   logic                                 rsp_dend_ff, rsp_dend_in;
   logic                                 rsp_mend_ff, rsp_mend_in;
   logic [mfrag_pkg::WORD_W-1:0]         rsp_dlen_ff, rsp_dlen_in;

   logic                                 out_free;
   logic [mfrag_pkg::LENGTH_BITS-1:0]    rem_eff;
   logic [mfrag_pkg::WORD_W-1:0]         pay_eff;
   logic [mfrag_pkg::WORD_W-1:0]         pleft_eff;
   logic [mfrag_pkg::WORD_W-1:0]         chunk;
   logic [mfrag_pkg::BYTE_W-1:0]         hdr_byte;
   logic                                 dend;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop    = (state_ff == BE_IDLE) && q_valid;

   // a new message restarts the datagram state
   assign rem_eff   = q_head.first ? q_head.length  : brem_ff;
   assign pay_eff   = q_head.first ? q_head.payload : pay_ff;
   assign pleft_eff = q_head.first ? '0             : pleft_ff;
   assign chunk     = (rem_eff < mfrag_pkg::LENGTH_BITS'(pay_eff))
                      ? rem_eff[mfrag_pkg::WORD_W-1:0] : pay_eff;

   // header byte at the current position
   always_comb begin
      case (hidx_ff)
         mfrag_pkg::HDR_MAGIC_HI: hdr_byte = mfrag_pkg::MAGIC_WORD[15:8];
         mfrag_pkg::HDR_MAGIC_LO: hdr_byte = mfrag_pkg::MAGIC_WORD[7:0];
         mfrag_pkg::HDR_ID_HI:    hdr_byte = cid_ff[15:8];
         mfrag_pkg::HDR_ID_LO:    hdr_byte = cid_ff[7:0];
         mfrag_pkg::HDR_SEQ_HI:   hdr_byte = seq_ff[15:8];
         mfrag_pkg::HDR_SEQ_LO:   hdr_byte = seq_ff[7:0];
         mfrag_pkg::HDR_TOTAL_HI: hdr_byte = total_ff[15:8];
         mfrag_pkg::HDR_TOTAL_LO: hdr_byte = total_ff[7:0];
         default:                 hdr_byte = '0;
      endcase
   end

   assign dend = (pleft_ff == mfrag_pkg::WORD_W'(1));

   // sequencer: fetch a transaction, send a header if a datagram opens, then the byte
   always_comb begin
      state_in     = state_ff;
      brem_in      = brem_ff;
      seq_in       = seq_ff;
      total_in     = total_ff;
      cid_in       = cid_ff;
      pay_in       = pay_ff;
      pleft_in     = pleft_ff;
      dlen_in      = dlen_ff;
      byte_in      = byte_ff;
      hidx_in      = hidx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_dend_in  = rsp_dend_ff;
      rsp_mend_in  = rsp_mend_ff;
      rsp_dlen_in  = rsp_dlen_ff;
      case (state_ff)
         BE_IDLE: begin
            if (q_valid) begin
               byte_in = q_head.data_byte;
               brem_in = rem_eff;
               pay_in  = pay_eff;
               if (q_head.first) begin
                  seq_in   = '0;
                  total_in = q_head.frag_total;
                  cid_in   = q_head.msg_id;
               end
               if (pleft_eff == '0) begin
                  pleft_in = chunk;
                  dlen_in  = chunk + mfrag_pkg::WORD_W'(mfrag_pkg::HDR_BYTES);
                  hidx_in  = mfrag_pkg::HDR_MAGIC_HI;
                  state_in = BE_HEADER;
               end else begin
                  pleft_in = pleft_eff;
                  state_in = BE_PAYLOAD;
               end
            end
         end
         BE_HEADER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = hdr_byte;
               rsp_dend_in  = 1'b0;
               rsp_mend_in  = 1'b0;
               rsp_dlen_in  = dlen_ff;
               hidx_in      = hidx_ff + mfrag_pkg::HDR_IDX_W'(1);
               if (hidx_ff == mfrag_pkg::HDR_TOTAL_LO) begin
                  state_in = BE_PAYLOAD;
               end
            end
         end
         BE_PAYLOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = byte_ff;
               rsp_dend_in  = dend;
               rsp_mend_in  = (brem_ff == mfrag_pkg::LENGTH_BITS'(1));
               rsp_dlen_in  = dlen_ff;
               pleft_in     = pleft_ff - mfrag_pkg::WORD_W'(1);
               brem_in      = brem_ff - mfrag_pkg::LENGTH_BITS'(1);
               if (dend) begin
                  seq_in = seq_ff + mfrag_pkg::WORD_W'(1);
               end
               state_in = BE_IDLE;
            end
         end
         default: begin
            state_in = BE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         brem_ff      <= '0;
         seq_ff       <= '0;
         total_ff     <= '0;
         cid_ff       <= '0;
         pay_ff       <= mfrag_pkg::WORD_W'(1);
         pleft_ff     <= '0;
         dlen_ff      <= '0;
         hidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         brem_ff      <= brem_in;
         seq_ff       <= seq_in;
         total_ff     <= total_in;
         cid_ff       <= cid_in;
         pay_ff       <= pay_in;
         pleft_ff     <= pleft_in;
         dlen_ff      <= dlen_in;
         hidx_ff      <= hidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_dend_ff <= rsp_dend_in;
      rsp_mend_ff <= rsp_mend_in;
      rsp_dlen_ff <= rsp_dlen_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dlen_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_dend_ff;
   assign rsp_tuser  = rsp_mend_ff;

endmodule

FILE: rtl/core/message_fragmenter_unit.sv
// path: a payload byte passes the job queue and the fetch and send steps of the back
//   end to the output register; a datagram start sends the eight header bytes first;
//   a message start waits for the fragment total from the bit-serial divider (one
//   quotient bit a cycle); each byte is sent before the back end fetches the next one
// reset: synchronous, active high; clears message id, sequencing state and the
//   queue, and loads the packet size register with 1472
module message_fragmenter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // data_byte [7:0], message_length [31:8]
   input  logic [mfrag_pkg::REQ_DATA_W-1:0]     req_tdata,
   // first_of_message [0]
   input  logic [0:0]                           req_tuser,
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_byte [7:0], datagram_length [23:8]
   output logic [mfrag_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   // message_end [0]
   output logic [0:0]                           rsp_tuser,
   // packet size write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mfrag_pkg::WORD_W-1:0]         csr_data
);

   logic                                 q_full;
   logic                                 q_push;
   logic                                 q_pop;
   logic                                 q_valid;
   mfrag_pkg::entry_type                 q_entry;
   mfrag_pkg::entry_type                 q_head;
   logic                                 div_start;
   logic [mfrag_pkg::LENGTH_BITS-1:0]    div_dividend;
   logic [mfrag_pkg::WORD_W-1:0]         div_divisor;
   mfrag_pkg::div_result_type            div_result;

   // register write is always taken
   assign csr_ready = 1'b1;

   // fragment total divider
   mfrag_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_result)
   );

   // accept and classify
   mfrag_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (q_entry),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_result   (div_result)
   );

   // job queue between front and back
   mfrag_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .valid      (q_valid),
      .head       (q_head)
   );

   // header insertion and byte output
   mfrag_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // queue is never written while full
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue written while full");

   // queue is only read when it holds an entry
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue read while empty");

   // no new request transaction while the divider runs
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      div_result.busy |-> !req_tready)
      else $error("request taken during division");

   // the last byte of a message also closes its datagram
   a_mend_dend: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("message end without datagram end");

endmodule

FILE: dv/message_fragmenter_unit_checker.sv
`timescale 1ns / 1ps

module message_fragmenter_unit_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // data_byte [7:0], message_length [31:8]
   input  logic [mfrag_pkg::REQ_DATA_W-1:0] req_tdata,
   // first_of_message [0]
   input  logic [0:0]                       req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_byte [7:0], datagram_length [23:8]
   input  logic [mfrag_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                             rsp_tlast,
   // message_end [0]
   input  logic [0:0]                       rsp_tuser,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [mfrag_pkg::WORD_W-1:0]     csr_data,
   output int                               mismatch_count,
   output int                               pending_count
);

   // one outgoing datagram byte with its marks
   typedef struct packed {
      logic [mfrag_pkg::BYTE_W-1:0] out_byte;
      logic                         datagram_end;
      logic                         message_end;
      logic [mfrag_pkg::WORD_W-1:0] datagram_length;
   } datagram_byte_type;

   datagram_byte_type bytes_due[$];
   datagram_byte_type seen_byte;
   datagram_byte_type due_byte;

   // fragmenter state as the block should hold it
   logic [mfrag_pkg::WORD_W-1:0]      packet_size_reg;
   logic [mfrag_pkg::WORD_W-1:0]      next_msg_id;
   logic [mfrag_pkg::WORD_W-1:0]      open_msg_id;
   logic [mfrag_pkg::WORD_W-1:0]      seq_no;
   logic [mfrag_pkg::WORD_W-1:0]      frag_total;
   logic [mfrag_pkg::WORD_W-1:0]      payload_size;
   logic [mfrag_pkg::WORD_W-1:0]      payload_left;
   logic [mfrag_pkg::WORD_W-1:0]      datagram_len;
   logic [mfrag_pkg::LENGTH_BITS-1:0] bytes_left;

   function automatic void queue_byte(input logic [mfrag_pkg::BYTE_W-1:0] value,
                                      input logic dgram_last, input logic msg_last);
      datagram_byte_type entry;
      entry.out_byte        = value;
      entry.datagram_end    = dgram_last;
      entry.message_end     = msg_last;
      entry.datagram_length = datagram_len;
      bytes_due = {bytes_due, entry};
   endfunction

   // oldest expected byte, taken off the list
   function automatic datagram_byte_type take_oldest_byte();
      datagram_byte_type oldest;
      oldest = bytes_due[0];
      bytes_due.delete(0);
      return oldest;
   endfunction

   // bytes that one accepted request transaction must produce
   function automatic void fragment_message_byte(
         input logic [mfrag_pkg::BYTE_W-1:0]    data,
         input logic                            first,
         input logic [mfrag_pkg::MSG_LEN_W-1:0] msg_len);
      logic [mfrag_pkg::WORD_W-1:0] eff_size;
      logic [31:0]                  len_used;
      logic [31:0]                  quotient;
      logic [31:0]                  chunk;
      logic [63:0]                  header;
      // a new message latches id, payload size and fragment total
      if (first) begin
         eff_size     = (packet_size_reg < mfrag_pkg::PKT_SIZE_MIN) ? mfrag_pkg::PKT_SIZE_MIN
                                                                    : packet_size_reg;
         len_used     = 32'(msg_len) & ((32'd1 << mfrag_pkg::LENGTH_BITS) - 32'd1);
         open_msg_id  = next_msg_id;
         next_msg_id  = next_msg_id + 16'd1;
         payload_size = eff_size - 16'(mfrag_pkg::HDR_BYTES);
         bytes_left   = len_used[mfrag_pkg::LENGTH_BITS-1:0];
         seq_no       = '0;
         quotient     = (len_used + 32'(payload_size) - 32'd1) / 32'(payload_size);
         frag_total   = quotient[mfrag_pkg::WORD_W-1:0];
         payload_left = '0;
         if (len_used == 32'd0) return;
      end
      // stray byte with no message open
      if (bytes_left == '0) return;
      // header in front of each datagram, big-endian
      if (payload_left == '0) begin
         chunk        = (32'(bytes_left) < 32'(payload_size)) ? 32'(bytes_left)
                                                              : 32'(payload_size);
         payload_left = chunk[mfrag_pkg::WORD_W-1:0];
         datagram_len = 16'(chunk + 32'(mfrag_pkg::HDR_BYTES));
         header       = {mfrag_pkg::MAGIC_WORD, open_msg_id, seq_no, frag_total};
         for (int i = mfrag_pkg::HDR_BYTES - 1; i >= 0; i--)
            queue_byte(header[i*8 +: 8], 1'b0, 1'b0);
      end
      payload_left = payload_left - 16'd1;
      bytes_left   = bytes_left - mfrag_pkg::LENGTH_BITS'(1);
      queue_byte(data, payload_left == '0, bytes_left == '0);
      if (payload_left == '0) seq_no = seq_no + 16'd1;
   endfunction

   function automatic void note_mismatch(input string what, input datagram_byte_type want,
                                         input datagram_byte_type got);
      if (mismatch_count < 10) begin
         $display("%0t: %s: expected byte %h dgram_end %b msg_end %b len %0d",
                  $realtime, what, want.out_byte, want.datagram_end, want.message_end,
                  want.datagram_length);
         $display("%0t: %s: got byte %h dgram_end %b msg_end %b len %0d",
                  $realtime, what, got.out_byte, got.datagram_end, got.message_end,
                  got.datagram_length);
      end
      mismatch_count++;
   endfunction

   // watch all three channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         packet_size_reg = mfrag_pkg::PKT_SIZE_RESET;
         next_msg_id     = '0;
         open_msg_id     = '0;
         seq_no          = '0;
         frag_total      = '0;
         payload_size    = 16'd1;
         payload_left    = '0;
         datagram_len    = '0;
         bytes_left      = '0;
         bytes_due.delete();
      end else begin
         // result transaction against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            seen_byte.out_byte        = rsp_tdata[mfrag_pkg::BYTE_W-1:0];
            seen_byte.datagram_end    = rsp_tlast;
            seen_byte.message_end     = rsp_tuser[0];
            seen_byte.datagram_length = rsp_tdata[mfrag_pkg::BYTE_W +: mfrag_pkg::WORD_W];
            if (bytes_due.size() == 0) begin
               note_mismatch("byte with nothing expected", '0, seen_byte);
            end else begin
               due_byte = take_oldest_byte();
               if (seen_byte !== due_byte) note_mismatch("byte mismatch", due_byte, seen_byte);
            end
         end
         // packet size write
         if (csr_valid && csr_ready) packet_size_reg = csr_data;
         // request transaction
         if (req_tvalid && req_tready)
            fragment_message_byte(req_tdata[mfrag_pkg::BYTE_W-1:0], req_tuser[0],
                                  req_tdata[mfrag_pkg::BYTE_W +: mfrag_pkg::MSG_LEN_W]);
      end
      pending_count = bytes_due.size();
   end

endmodule

FILE: dv/message_fragmenter_unit_test.sv
`timescale 1ns / 1ps

module message_fragmenter_unit_test;

   localparam int RANDOM_ITEMS    = 345;
   localparam int SETTLE_CYCLES   = 48;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int TIMEOUT_NS      = 5_000_000;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [mfrag_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [0:0]                       req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [mfrag_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             rsp_tlast;
   logic [0:0]                       rsp_tuser;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [mfrag_pkg::WORD_W-1:0]     csr_data   = '0;

   int mismatch_count;
   int pending_count;

   // pacing controls for sender and receiver, set by the stimulus
   bit tx_calm       = 1'b1;
   bit rx_calm       = 1'b1;
   int rx_hold_cycles = 0;

   always #5 clock = ~clock;

   message_fragmenter_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   message_fragmenter_unit_checker frag_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // one request transaction, after a random gap unless the sender is calm
   task automatic send_item(input logic [mfrag_pkg::BYTE_W-1:0] data, input logic first,
                            input logic [mfrag_pkg::MSG_LEN_W-1:0] msg_len);
      int gap;
      gap = tx_calm ? 0 : int'($urandom_range(0, 9));
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {msg_len, data};
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
   endtask

   // opening byte plus the rest, random content
   task automatic send_message(input logic [mfrag_pkg::MSG_LEN_W-1:0] msg_len,
                               input int nbytes);
      send_item(8'($urandom_range(0, 255)), 1'b1, msg_len);
      for (int i = 1; i < nbytes; i++)
         send_item(8'($urandom_range(0, 255)), 1'b0, mfrag_pkg::MSG_LEN_W'($urandom()));
   endtask

   // stop offering and wait for every expected byte, then let the block settle
   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_packet_size(input logic [mfrag_pkg::WORD_W-1:0] size);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= size;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stalls per transaction unless calm, plus a long hold-off on request
   initial begin : receiver
      int stall;
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rx_hold_cycles) @(negedge clock);
            rx_hold_cycles = 0;
         end
         stall = rx_calm ? 0 : int'($urandom_range(0, 9));
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int                                items;
      int                                kind;
      int                                nbytes;
      logic [mfrag_pkg::MSG_LEN_W-1:0]   len;
      logic [mfrag_pkg::WORD_W-1:0]      size;
      bit                                msg_open;
      bit                                hold_done;
      items     = 0;
      msg_open  = 1'b0;
      hold_done = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stray byte, then an empty message, then a short one at the reset size
      send_item(8'hA5, 1'b0, 24'hFFFFFF);
      send_item(8'hFF, 1'b1, 24'd0);
      send_item(8'h00, 1'b1, 24'd3);
      send_item(8'hFF, 1'b0, 24'd0);
      send_item(8'h5A, 1'b0, 24'd0);

      // size below the minimum: one payload byte per datagram
      drain();
      write_packet_size(16'd0);
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      send_item(8'h3C, 1'b1, 24'd2);
      send_item(8'hC3, 1'b0, 24'd0);

      // size change in the middle of a message applies only to the next one
      drain();
      write_packet_size(16'd12);
      send_item(8'h11, 1'b1, 24'd10);
      send_item(8'h22, 1'b0, 24'd0);
      send_item(8'h33, 1'b0, 24'd0);
      drain();
      write_packet_size(16'd65507);
      for (int i = 0; i < 7; i++) send_item(8'($urandom_range(0, 255)), 1'b0, 24'd0);

      // early new message cuts off a long one
      send_message(24'hFFFFFF, 2);
      send_message(24'd1, 1);

      // fragment total wraps at 16 bits, then an empty message cuts it off
      drain();
      write_packet_size(16'd9);
      send_message(24'h012345, 1);
      send_item(8'h00, 1'b1, 24'd0);

      // largest size
      drain();
      write_packet_size(16'd65507);
      send_message(24'd1, 1);

      // random messages, mostly well formed
      while (items < RANDOM_ITEMS) begin
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);

         // occasional size change while idle
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 9))
               0:       size = 16'($urandom_range(0, 8));
               1:       size = 16'd65507;
               2:       size = 16'($urandom_range(9, 65507));
               default: size = 16'($urandom_range(9, 24));
            endcase
            drain();
            write_packet_size(size);
         end

         // long receiver hold-off while the sender keeps pushing
         if (!hold_done && items >= 100) begin
            rx_hold_cycles = HOLD_OFF_CYCLES;
            tx_calm        = 1'b1;
            hold_done      = 1'b1;
         end

         kind = int'($urandom_range(0, 15));
         case (kind)
            0: begin
               if (!msg_open)
                  send_item(8'($urandom_range(0, 255)), 1'b0,
                            mfrag_pkg::MSG_LEN_W'($urandom()));
            end
            1: begin
               send_message(24'd0, 1);
               items++;
               msg_open = 1'b0;
            end
            2, 3: begin
               // declared length random or longer than what is sent
               nbytes = int'($urandom_range(1, 8));
               if ($urandom_range(0, 1))
                  len = mfrag_pkg::MSG_LEN_W'($urandom());
               else
                  len = mfrag_pkg::MSG_LEN_W'(nbytes + int'($urandom_range(1, 20)));
               send_message(len, nbytes);
               items += nbytes;
               msg_open = (int'(len) > nbytes);
            end
            default: begin
               if ($urandom_range(0, 4) == 0) len = mfrag_pkg::MSG_LEN_W'($urandom_range(13, 40));
               else                           len = mfrag_pkg::MSG_LEN_W'($urandom_range(1, 12));
               send_message(len, int'(len));
               items += int'(len);
               msg_open = 1'b0;
            end
         endcase
      end

      drain();
      if (mismatch_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/mfrag_pkg.sv
rtl/core/mfrag_divider.sv
rtl/core/mfrag_queue.sv
rtl/core/mfrag_front.sv
rtl/core/mfrag_back.sv
rtl/core/message_fragmenter_unit.sv
dv/message_fragmenter_unit_checker.sv
dv/message_fragmenter_unit_test.sv
